FILE: sv/bofc_pkg.sv
// ----------------------------------------------------------------------------
// bofc_pkg
// Shared types, constants and the byte merge function for the bit field copy.
// ----------------------------------------------------------------------------
package bofc_pkg;

    localparam int unsigned MAX_FIELD_BITS_DEF = 65535;
    localparam int unsigned CNT_W             = 15;
    localparam int unsigned IDX_W             = 14;
    localparam int unsigned CFG_IDX_W         = 2;
    localparam int unsigned CFG_DATA_W        = 16;
    localparam int unsigned FIFO_DEPTH        = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_OFF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DST_OFF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT = 2'd2;

    localparam logic [15:0] BIT_COUNT_RST = 16'd8;

    typedef struct packed {
        logic [7:0] src_byte;
        logic [7:0] dst_old_byte;
        logic       end_of_stream;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic [IDX_W-1:0] out_index;
        logic             out_last;
    } t_out_beat;

    typedef struct packed {
        logic [2:0]  src_off;
        logic [2:0]  dst_off;
        logic [15:0] bit_count;
    } t_cfg;

    typedef struct packed {
        logic      push0;
        logic      push1;
        t_out_beat d0;
        t_out_beat d1;
    } t_push;

    // combo: source bytes j-1, j, j+1 from bit 0 upward
    function automatic logic [7:0] merge_byte(
        input logic        first,
        input logic        last,
        input logic [23:0] combo,
        input logic [7:0]  old,
        input logic [2:0]  src_off,
        input logic [2:0]  dst_off,
        input logic [2:0]  end_bits
    );
        logic [3:0]  sa;
        logic [23:0] sh;
        logic [3:0]  hi;
        logic [8:0]  m_hi;
        logic [7:0]  m_lo;
        logic [7:0]  mask;
        sa   = 4'd8 + {1'b0, src_off} - {1'b0, dst_off};
        sh   = combo >> sa;
        hi   = last ? {1'b0, end_bits} : 4'd8;
        m_hi = (9'd1 << hi) - 9'd1;
        m_lo = first ? ~((8'd1 << dst_off) - 8'd1) : 8'hFF;
        mask = m_hi[7:0] & m_lo;
        return (sh[7:0] & mask) | (old & ~mask);
    endfunction

endpackage

FILE: sv/bofc_core.sv
// ----------------------------------------------------------------------------
// bofc_core
// Input register, source window state and merge of up to two result beats.
// ----------------------------------------------------------------------------
module bofc_core #(
    parameter int unsigned MAX_FIELD_BITS = bofc_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  bofc_pkg::t_in_beat i_in_data,
    output logic               o_in_stall,
    input  bofc_pkg::t_cfg     i_cfg,
    input  logic               i_room,
    output bofc_pkg::t_push    o_push
);

    localparam logic [20:0] MaxBits = 21'(MAX_FIELD_BITS);

    logic                          r_in_valid, n_in_valid;
    bofc_pkg::t_in_beat            r_in;
    logic [15:0]                   r_win;
    logic [7:0]                    r_dst_pend;
    logic [bofc_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          r_have, n_have;

    logic                          accept, fire;
    logic [15:0]                   eff;
    logic [16:0]                   fend;
    logic [bofc_pkg::CNT_W-1:0]    last_idx, k_prev;
    logic                          emit_prev, emit_cur;

    assign fire       = r_in_valid && i_room;
    assign o_in_stall = r_in_valid && !i_room;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_in_valid = accept || (r_in_valid && !fire);

    assign eff      = ({5'd0, i_cfg.bit_count} > MaxBits) ? MaxBits[15:0] : i_cfg.bit_count;
    assign fend     = {14'd0, i_cfg.dst_off} + {1'b0, eff};
    assign last_idx = {1'b0, fend[16:3]};
    assign k_prev   = r_cnt - 1'b1;

    assign emit_prev = r_have && (r_cnt != '0) && (k_prev <= last_idx);
    assign emit_cur  = r_in.end_of_stream && (r_cnt <= last_idx);

    always_comb begin
        o_push.push0 = fire && emit_prev;
        o_push.push1 = fire && emit_cur;
        o_push.d0.out_byte  = bofc_pkg::merge_byte(k_prev == '0, k_prev == last_idx,
            {r_in.src_byte, r_win}, r_dst_pend, i_cfg.src_off, i_cfg.dst_off, fend[2:0]);
        o_push.d0.out_index = k_prev[bofc_pkg::IDX_W-1:0];
        o_push.d0.out_last  = (k_prev == last_idx) || (r_in.end_of_stream && !emit_cur);
        o_push.d1.out_byte  = bofc_pkg::merge_byte(r_cnt == '0, r_cnt == last_idx,
            {8'd0, r_in.src_byte, r_win[15:8]}, r_in.dst_old_byte,
            i_cfg.src_off, i_cfg.dst_off, fend[2:0]);
        o_push.d1.out_index = r_cnt[bofc_pkg::IDX_W-1:0];
        o_push.d1.out_last  = 1'b1;
    end

    always_comb begin
        n_cnt  = r_cnt;
        n_have = r_have;
        if (fire) begin
            if (r_in.end_of_stream) begin
                n_cnt  = '0;
                n_have = 1'b0;
            end else begin
                n_have = 1'b1;
                if (r_cnt != '1) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= '0;
            r_have     <= 1'b0;
            r_win      <= '0;
            r_dst_pend <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            r_cnt      <= n_cnt;
            r_have     <= n_have;
            if (fire) begin
                if (r_in.end_of_stream) begin
                    r_win      <= '0;
                    r_dst_pend <= '0;
                end else begin
                    r_win      <= {r_in.src_byte, r_win[15:8]};
                    r_dst_pend <= r_in.dst_old_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.end_of_stream |=> (r_cnt == '0) && !r_have)
        else $error("state not cleared after end beat");

    a_pend_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_cnt != '0))
        else $error("pending byte without count");

    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in))
        else $error("held input beat lost");

endmodule

FILE: sv/bofc_ofifo.sv
// ----------------------------------------------------------------------------
// bofc_ofifo
// Four-entry result queue taking up to two beats per cycle.
// ----------------------------------------------------------------------------
module bofc_ofifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bofc_pkg::t_push     i_push,
    output logic                o_room,
    output logic                o_out_valid,
    output bofc_pkg::t_out_beat o_out_data,
    input  logic                i_out_stall
);

    localparam int unsigned PtrW = $clog2(bofc_pkg::FIFO_DEPTH);

    bofc_pkg::t_out_beat  r_mem [bofc_pkg::FIFO_DEPTH];
    logic [PtrW-1:0]      r_wr, n_wr;
    logic [PtrW-1:0]      r_rd, n_rd;
    logic [PtrW:0]        r_count, n_count;
    logic                 pop;
    logic [1:0]           n_push;

    assign pop         = o_out_valid && !i_out_stall;
    assign o_out_valid = r_count != '0;
    assign o_out_data  = r_mem[r_rd];
    assign o_room      = r_count <= (PtrW+1)'(bofc_pkg::FIFO_DEPTH - 2);
    assign n_push      = {1'b0, i_push.push0} + {1'b0, i_push.push1};

    assign n_wr    = r_wr + PtrW'(n_push);
    assign n_rd    = r_rd + PtrW'(pop);
    assign n_count = r_count + (PtrW+1)'(n_push) - (PtrW+1)'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) begin
            r_mem[r_wr] <= i_push.d0;
        end
        if (i_push.push1) begin
            r_mem[i_push.push0 ? r_wr + 1'b1 : r_wr] <= i_push.d1;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.push0 || i_push.push1) |-> o_room)
        else $error("push into full queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PtrW+1)'(bofc_pkg::FIFO_DEPTH))
        else $error("queue count out of range");

endmodule

FILE: sv/bit_offset_field_copy.sv
// ----------------------------------------------------------------------------
// bit_offset_field_copy
// Copies a bit field between byte streams at arbitrary source and
// destination bit offsets, merging with the old destination bytes.
// ----------------------------------------------------------------------------
// Throughput: one input beat per cycle while the result queue has room; the
// end beat may give two results, drained by a four-entry result queue at one
// beat per cycle while the receiver does not stall.
// Reset: synchronous, active low; clears copy state and sets registers to
// source offset 0, destination offset 0, bit count 8.
module bit_offset_field_copy #(
    parameter int unsigned MAX_FIELD_BITS = bofc_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  bofc_pkg::t_in_beat                  i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output bofc_pkg::t_out_beat                 o_out_data,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_we,
    input  logic [bofc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bofc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    bofc_pkg::t_cfg  r_cfg;
    bofc_pkg::t_push push;
    logic            room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_off   <= '0;
            r_cfg.dst_off   <= '0;
            r_cfg.bit_count <= bofc_pkg::BIT_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bofc_pkg::REG_SRC_OFF:   r_cfg.src_off   <= i_cfg_wdata[2:0];
                bofc_pkg::REG_DST_OFF:   r_cfg.dst_off   <= i_cfg_wdata[2:0];
                bofc_pkg::REG_BIT_COUNT: r_cfg.bit_count <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    bofc_core #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_cfg      (r_cfg),
        .i_room     (room),
        .o_push     (push)
    );

    bofc_ofifo u_ofifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: dv/bit_offset_field_copy_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bit_offset_field_copy_tb
// Self-checking bench for the bit field copy. A queue-fed driver sends source
// and old destination bytes, a predictor works out every merged output byte,
// and a monitor checks each output beat against the oldest expected one.
// Directed copies cover offsets, zero length, early end and spare writes;
// then a copy at the largest bit count, a long receiver hold-off and random
// copies.
// ----------------------------------------------------------------------------
module bit_offset_field_copy_tb;

    localparam logic [bofc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned RAND_ITEMS   = 680;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_in_valid  = 1'b0;
    bofc_pkg::t_in_beat               i_in_data   = '0;
    logic                             o_in_stall;
    logic                             o_out_valid;
    bofc_pkg::t_out_beat              o_out_data;
    logic                             i_out_stall = 1'b0;
    logic                             i_cfg_we    = 1'b0;
    logic [bofc_pkg::CFG_IDX_W-1:0]   i_cfg_idx   = '0;
    logic [bofc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    bit_offset_field_copy u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    bofc_pkg::t_in_beat    pending_beats[$];
    bofc_pkg::t_out_beat   expected_bytes[$];
    int unsigned err_count   = 0;
    int unsigned cycle_count = 0;
    logic        in_taken    = 1'b0;
    logic        out_taken   = 1'b0;
    bit          tx_idle_en  = 1'b1;
    bit          rx_idle_en  = 1'b1;
    int unsigned tx_gap      = 0;
    int unsigned rx_wait     = 0;
    int unsigned rx_hold_req = 0;
    int unsigned rx_hold_cnt = 0;

    // predictor copy of registers and copy state
    logic [2:0]  mdl_src  = 3'd0;
    logic [2:0]  mdl_dst  = 3'd0;
    logic [15:0] mdl_bits = bofc_pkg::BIT_COUNT_RST;
    logic [15:0] src_win  = '0;
    logic [7:0]  dst_hold = '0;
    logic [23:0] copy_cnt = '0;
    bit          has_prev = 1'b0;

    function automatic int unsigned field_bits();
        return (mdl_bits > bofc_pkg::MAX_FIELD_BITS_DEF) ?
            bofc_pkg::MAX_FIELD_BITS_DEF : int'(mdl_bits);
    endfunction

    // src3: source bytes j-1, j, j+1 from bit 0 upward
    function automatic logic [7:0] merge_field_bits(int unsigned j, logic [23:0] src3,
                                                    logic [7:0] old);
        int unsigned bit_pos;
        int          src_pos;
        logic [7:0]  merged;
        merged = old;
        for (int b = 0; b < 8; b++) begin
            bit_pos = j * 8 + b;
            if (bit_pos >= mdl_dst && bit_pos < mdl_dst + field_bits()) begin
                src_pos   = 8 + b + int'(mdl_src) - int'(mdl_dst);
                merged[b] = src3[src_pos];
            end
        end
        return merged;
    endfunction

    task automatic predict_copy_bytes(bofc_pkg::t_in_beat beat);
        int unsigned         k;
        int unsigned         last_idx;
        logic [15:0]         nxt_win;
        bit                  emit_prev;
        bit                  emit_cur;
        bofc_pkg::t_out_beat res;
        k         = copy_cnt;
        last_idx  = (mdl_dst + field_bits()) / 8;
        nxt_win   = {beat.src_byte, src_win[15:8]};
        emit_prev = has_prev && k >= 1 && (k - 1) <= last_idx;
        emit_cur  = beat.end_of_stream && k <= last_idx;
        if (emit_prev) begin
            res.out_byte  = merge_field_bits(k - 1, {beat.src_byte, src_win}, dst_hold);
            res.out_index = (bofc_pkg::IDX_W)'(k - 1);
            res.out_last  = ((k - 1) == last_idx) || (beat.end_of_stream && !emit_cur);
            expected_bytes.push_back(res);
        end
        if (emit_cur) begin
            // bytes past an early end read as zero
            res.out_byte  = merge_field_bits(k, {8'h00, nxt_win}, beat.dst_old_byte);
            res.out_index = (bofc_pkg::IDX_W)'(k);
            res.out_last  = 1'b1;
            expected_bytes.push_back(res);
        end
        if (beat.end_of_stream) begin
            src_win  = '0;
            dst_hold = '0;
            copy_cnt = '0;
            has_prev = 1'b0;
        end else begin
            src_win  = nxt_win;
            dst_hold = beat.dst_old_byte;
            has_prev = 1'b1;
            if (copy_cnt != 24'hFFFFFF) copy_cnt = copy_cnt + 24'd1;
        end
    endtask

    // monitor: result check, register mirror, prediction on accepted input beats
    always @(posedge i_clk) begin
        bofc_pkg::t_out_beat exp_b;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected output beat: byte %0h index %0d last %0b",
                           o_out_data.out_byte, o_out_data.out_index, o_out_data.out_last);
                    err_count++;
                end else begin
                    exp_b = expected_bytes.pop_front();
                    if (o_out_data.out_byte !== exp_b.out_byte) begin
                        $error("out_byte: expected %0h, actual %0h",
                               exp_b.out_byte, o_out_data.out_byte);
                        err_count++;
                    end
                    if (o_out_data.out_index !== exp_b.out_index) begin
                        $error("out_index: expected %0d, actual %0d",
                               exp_b.out_index, o_out_data.out_index);
                        err_count++;
                    end
                    if (o_out_data.out_last !== exp_b.out_last) begin
                        $error("out_last: expected %0b, actual %0b",
                               exp_b.out_last, o_out_data.out_last);
                        err_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bofc_pkg::REG_SRC_OFF: begin
                        mdl_src = i_cfg_wdata[2:0];
                    end
                    bofc_pkg::REG_DST_OFF: begin
                        mdl_dst = i_cfg_wdata[2:0];
                    end
                    bofc_pkg::REG_BIT_COUNT: begin
                        mdl_bits = i_cfg_wdata[15:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !o_in_stall) predict_copy_bytes(i_in_data);
        end
        in_taken  <= i_rst_n && i_in_valid && !o_in_stall;
        out_taken <= i_rst_n && o_out_valid && !i_out_stall;
    end

    // driver: one beat at a time from the pending queue, random gaps between beats
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                i_in_data  <= pending_beats.pop_front();
                i_in_valid <= 1'b1;
                tx_gap = tx_idle_en ? $urandom_range(0, 15) : 0;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall per beat, plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_cnt = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_cnt > 0) begin
            rx_hold_cnt--;
            i_out_stall <= 1'b1;
        end else begin
            if (out_taken) rx_wait = rx_idle_en ? $urandom_range(0, 15) : 0;
            if (rx_wait > 0) begin
                rx_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("bit_offset_field_copy test failed");
            $finish;
        end
    end

    // stimulus side view of the field, for sizing copies
    int unsigned st_dst  = 0;
    int unsigned st_bits = 8;

    task automatic settle();
        do @(posedge i_clk);
        while (pending_beats.size() != 0 || i_in_valid || expected_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [bofc_pkg::CFG_IDX_W-1:0] idx,
                             logic [bofc_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // upper bits of the offset writes are random and must be ignored
    task automatic set_copy(logic [2:0] src, logic [2:0] dst, logic [15:0] bits);
        settle();
        write_reg(bofc_pkg::REG_SRC_OFF, {13'($urandom), src});
        write_reg(bofc_pkg::REG_DST_OFF, {13'($urandom), dst});
        write_reg(bofc_pkg::REG_BIT_COUNT, bits);
        st_dst  = dst;
        st_bits = bits;
    endtask

    task automatic push_beat(logic [7:0] src, logic [7:0] old, logic eos);
        bofc_pkg::t_in_beat b;
        b.src_byte      = src;
        b.dst_old_byte  = old;
        b.end_of_stream = eos;
        pending_beats.push_back(b);
    endtask

    task automatic push_copy(int unsigned n, bit with_end);
        for (int unsigned i = 0; i < n; i++)
            push_beat(8'($urandom), 8'($urandom), with_end && (i == n - 1));
    endtask

    initial begin
        int unsigned counted;
        int unsigned last_idx;
        int unsigned n;
        int unsigned sel;
        logic [15:0] bits;
        counted = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // registers at their reset values
        push_beat(8'hA5, 8'h3C, 1'b0);
        push_beat(8'h5A, 8'hC3, 1'b1);
        // widest shift down
        set_copy(3'd7, 3'd0, 16'd17);
        push_beat(8'hFF, 8'h00, 1'b0);
        push_beat(8'h00, 8'hFF, 1'b0);
        push_beat(8'hFF, 8'h00, 1'b1);
        // one bit at the top of byte 0
        set_copy(3'd0, 3'd7, 16'd1);
        push_beat(8'h01, 8'h00, 1'b0);
        push_beat(8'hFE, 8'hFF, 1'b1);
        // zero length: old bytes pass through
        set_copy(3'd3, 3'd5, 16'd0);
        push_beat(8'hFF, 8'h5A, 1'b1);
        push_beat(8'h00, 8'hA5, 1'b0);
        push_beat(8'hFF, 8'h3C, 1'b1);
        // early end, missing source bytes read as zero
        set_copy(3'd3, 3'd2, 16'd40);
        push_beat(8'hC3, 8'h81, 1'b0);
        push_beat(8'h7E, 8'h18, 1'b0);
        push_beat(8'hFF, 8'hE7, 1'b1);
        // beats past the field give nothing
        set_copy(3'd0, 3'd0, 16'd8);
        push_copy(5, 1'b1);
        // spare register index must be ignored
        settle();
        write_reg(REG_SPARE, 16'hFFFF);
        push_copy(2, 1'b1);
        // reconfigure in the middle of a copy, sender paused until drained
        set_copy(3'd1, 3'd2, 16'd30);
        push_copy(2, 1'b0);
        settle();
        write_reg(bofc_pkg::REG_SRC_OFF, 16'd6);
        push_copy(3, 1'b1);

        // longest field, ended early
        settle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        set_copy(3'd7, 3'd7, 16'hFFFF);
        push_copy(64, 1'b1);

        // receiver holds off while the sender keeps going
        set_copy(3'd2, 3'd5, 16'd300);
        push_copy(39, 1'b1);
        rx_hold_req = 400;
        settle();

        while (counted < RAND_ITEMS) begin
            settle();
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0) write_reg(bofc_pkg::REG_BIT_COUNT, 16'($urandom));
            sel = $urandom_range(0, 9);
            if (sel < 6)      bits = 16'($urandom_range(0, 24));
            else if (sel < 9) bits = 16'($urandom_range(25, 120));
            else              bits = 16'($urandom_range(121, 400));
            set_copy(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), bits);
            last_idx = (st_dst + st_bits) / 8;
            repeat ($urandom_range(1, 3)) begin
                sel = $urandom_range(0, 9);
                if (sel < 6)      n = last_idx + 1;
                else if (sel < 8) n = last_idx + 2;
                else if (sel < 9) n = $urandom_range(1, (last_idx > 0) ? last_idx : 1);
                else              n = last_idx + 2 + $urandom_range(1, 4);
                push_copy(n, 1'b1);
                counted += (n < last_idx + 2) ? n : last_idx + 2;
            end
        end

        settle();
        if (err_count == 0) begin
            $display("bit_offset_field_copy test passed");
        end else begin
            $display("bit_offset_field_copy test failed");
        end
        $finish;
    end

endmodule
